FILE: hdl/sts_pkg.sv
package sts_pkg;

    // token kinds
    localparam logic [2:0] KIND_NUMBER   = 3'd0;
    localparam logic [2:0] KIND_QSTRING  = 3'd1;
    localparam logic [2:0] KIND_BAREWORD = 3'd2;
    localparam logic [2:0] KIND_SYMBOL   = 3'd3;
    localparam logic [2:0] KIND_EOF      = 3'd4;

    localparam int CHAR_W = 8;
    localparam int LINE_W = 16;
    localparam int COL_W  = 12;

    // one result word
    typedef struct packed {
        logic [2:0]        kind;
        logic [CHAR_W-1:0] ch;
        logic              first;
        logic              last;
        logic              empty;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
    } t_res;

    // results produced by one scanned byte
    typedef struct packed {
        logic [1:0] cnt;
        t_res       r0;
        t_res       r1;
    } t_push;

endpackage

FILE: hdl/sts_scan.sv
module sts_scan
    import sts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [CHAR_W-1:0] i_char,
    input  logic              i_end,
    input  logic [7:0]        i_max_len,
    output t_push             o_push
);

    localparam logic [2:0] M_IDLE     = 3'd0;
    localparam logic [2:0] M_SLASH    = 3'd1;
    localparam logic [2:0] M_COMMENT  = 3'd2;
    localparam logic [2:0] M_NUMBER   = 3'd3;
    localparam logic [2:0] M_QSTRING  = 3'd4;
    localparam logic [2:0] M_BAREWORD = 3'd5;
    localparam logic [2:0] M_CMP      = 3'd6;

    localparam logic [7:0] C_SLASH = 8'h2F;
    localparam logic [7:0] C_QUOTE = 8'h22;
    localparam logic [7:0] C_DOT   = 8'h2E;
    localparam logic [7:0] C_UNDER = 8'h5F;
    localparam logic [7:0] C_GT    = 8'h3E;
    localparam logic [7:0] C_LT    = 8'h3C;
    localparam logic [7:0] C_EQ    = 8'h3D;
    localparam logic [7:0] C_BANG  = 8'h21;
    localparam logic [7:0] C_NL    = 8'h0A;

    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
    localparam logic [COL_W-1:0]  COL_MAX  = {COL_W{1'b1}};

    logic [2:0]        r_mode, n_mode;
    logic [CHAR_W-1:0] r_held_char, n_held_char;
    logic              r_held_valid, n_held_valid;
    logic              r_held_first, n_held_first;
    logic [7:0]        r_tok_len, n_tok_len;
    logic [LINE_W-1:0] r_line, n_line;
    logic [COL_W-1:0]  r_col, n_col;
    logic [LINE_W-1:0] r_tok_line, n_tok_line;
    logic [COL_W-1:0]  r_tok_col, n_tok_col;
    logic              r_ended, n_ended;

    t_res       w_res [2];
    logic [1:0] w_cnt;

    function automatic t_res mk_res(logic [2:0] kind, logic [CHAR_W-1:0] ch, logic first,
                                    logic last, logic empty, logic [LINE_W-1:0] line,
                                    logic [COL_W-1:0] col);
        t_res r;
        r.kind  = kind;
        r.ch    = ch;
        r.first = first;
        r.last  = last;
        r.empty = empty;
        r.line  = line;
        r.col   = col;
        return r;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_cmp(logic [7:0] c);
        return c == C_GT || c == C_LT || c == C_EQ || c == C_BANG;
    endfunction

    logic [2:0] w_held_kind;
    logic [7:0] w_limit;

    always_comb begin
        unique case (r_mode)
            M_NUMBER:   w_held_kind = KIND_NUMBER;
            M_QSTRING:  w_held_kind = KIND_QSTRING;
            M_BAREWORD: w_held_kind = KIND_BAREWORD;
            default:    w_held_kind = KIND_SYMBOL;
        endcase
    end

    // a zero length register acts as one
    assign w_limit = (i_max_len == 8'd0) ? 8'd1 : i_max_len;

    always_comb begin
        logic v_ext;
        logic v_member;
        logic v_idle;
        n_mode       = r_mode;
        n_held_char  = r_held_char;
        n_held_valid = r_held_valid;
        n_held_first = r_held_first;
        n_tok_len    = r_tok_len;
        n_line       = r_line;
        n_col        = r_col;
        n_tok_line   = r_tok_line;
        n_tok_col    = r_tok_col;
        n_ended      = r_ended;
        w_res[0]     = '0;
        w_res[1]     = '0;
        w_cnt        = 2'd0;
        v_ext        = 1'b0;
        v_member     = 1'b0;
        v_idle       = 1'b0;

        if (r_ended) begin
            w_res[0] = mk_res(KIND_EOF, '0, 1'b1, 1'b1, 1'b1, r_line, r_col);
            w_cnt    = 2'd1;
        end else if (i_end) begin
            // flush what is pending, then the end-of-file token
            if (r_mode == M_SLASH) begin
                w_res[0] = mk_res(KIND_SYMBOL, C_SLASH, 1'b1, 1'b1, 1'b0,
                                  r_tok_line, r_tok_col);
                w_cnt    = 2'd1;
            end else if (r_mode == M_QSTRING && !r_held_valid) begin
                w_res[0] = mk_res(KIND_QSTRING, '0, 1'b1, 1'b1, 1'b1, r_tok_line, r_tok_col);
                w_cnt    = 2'd1;
            end else if (r_mode >= M_NUMBER && r_mode <= M_CMP && r_held_valid) begin
                w_res[0] = mk_res(w_held_kind, r_held_char, r_held_first, 1'b1, 1'b0,
                                  r_tok_line, r_tok_col);
                w_cnt    = 2'd1;
            end
            w_res[w_cnt[0]] = mk_res(KIND_EOF, '0, 1'b1, 1'b1, 1'b1, r_line, r_col);
            w_cnt           = w_cnt + 2'd1;
            n_mode          = M_IDLE;
            n_held_valid    = 1'b0;
            n_ended         = 1'b1;
        end else begin
            unique case (r_mode)
                M_COMMENT: begin
                    if (i_char == C_NL) n_mode = M_IDLE;
                end
                M_SLASH: begin
                    if (i_char == C_SLASH) begin
                        n_mode = M_COMMENT;
                    end else begin
                        w_res[0] = mk_res(KIND_SYMBOL, C_SLASH, 1'b1, 1'b1, 1'b0,
                                          r_tok_line, r_tok_col);
                        w_cnt    = 2'd1;
                        v_idle   = 1'b1;
                    end
                end
                M_NUMBER: begin
                    v_ext    = 1'b1;
                    v_member = is_digit(i_char) || i_char == C_DOT;
                end
                M_BAREWORD: begin
                    v_ext    = 1'b1;
                    v_member = is_alpha(i_char) || is_digit(i_char) || i_char == C_UNDER;
                end
                M_CMP: begin
                    v_ext    = 1'b1;
                    v_member = is_cmp(i_char);
                end
                M_QSTRING: begin
                    if (i_char == C_QUOTE) begin
                        if (r_held_valid) begin
                            w_res[0] = mk_res(KIND_QSTRING, r_held_char, r_held_first, 1'b1,
                                              1'b0, r_tok_line, r_tok_col);
                        end else begin
                            w_res[0] = mk_res(KIND_QSTRING, '0, 1'b1, 1'b1, 1'b1,
                                              r_tok_line, r_tok_col);
                        end
                        w_cnt        = 2'd1;
                        n_held_valid = 1'b0;
                        n_mode       = M_IDLE;
                    end else if (!r_held_valid) begin
                        n_held_char  = i_char;
                        n_held_valid = 1'b1;
                        n_held_first = 1'b1;
                        n_tok_len    = 8'd1;
                    end else begin
                        v_ext    = 1'b1;
                        v_member = 1'b1;
                    end
                end
                default: v_idle = 1'b1;
            endcase

            // grow the token, or close it and rescan this byte
            if (v_ext) begin
                if (v_member && r_tok_len < w_limit) begin
                    w_res[0]     = mk_res(w_held_kind, r_held_char, r_held_first, 1'b0, 1'b0,
                                          r_tok_line, r_tok_col);
                    w_cnt        = 2'd1;
                    n_held_char  = i_char;
                    n_held_first = 1'b0;
                    n_tok_len    = r_tok_len + 8'd1;
                end else begin
                    w_res[0]     = mk_res(w_held_kind, r_held_char, r_held_first, 1'b1, 1'b0,
                                          r_tok_line, r_tok_col);
                    w_cnt        = 2'd1;
                    n_held_valid = 1'b0;
                    v_idle       = 1'b1;
                end
            end

            // between tokens
            if (v_idle) begin
                n_mode = M_IDLE;
                if (!is_space(i_char)) begin
                    n_tok_line = r_line;
                    n_tok_col  = r_col;
                    if (i_char == C_SLASH) begin
                        n_mode = M_SLASH;
                    end else if (i_char == C_QUOTE) begin
                        n_mode       = M_QSTRING;
                        n_held_valid = 1'b0;
                        n_tok_len    = 8'd0;
                    end else if (is_digit(i_char) || is_alpha(i_char) || i_char == C_UNDER
                                 || is_cmp(i_char)) begin
                        if (is_digit(i_char))      n_mode = M_NUMBER;
                        else if (is_cmp(i_char))   n_mode = M_CMP;
                        else                       n_mode = M_BAREWORD;
                        n_held_char  = i_char;
                        n_held_valid = 1'b1;
                        n_held_first = 1'b1;
                        n_tok_len    = 8'd1;
                    end else begin
                        w_res[w_cnt[0]] = mk_res(KIND_SYMBOL, i_char, 1'b1, 1'b1, 1'b0,
                                                 r_line, r_col);
                        w_cnt           = w_cnt + 2'd1;
                    end
                end
            end

            // position, saturating
            if (i_char == C_NL) begin
                if (r_line != LINE_MAX) n_line = r_line + 1'b1;
                n_col = COL_W'(1);
            end else if (r_col != COL_MAX) begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_IDLE;
            r_held_char  <= '0;
            r_held_valid <= 1'b0;
            r_held_first <= 1'b0;
            r_tok_len    <= '0;
            r_line       <= LINE_W'(1);
            r_col        <= COL_W'(1);
            r_tok_line   <= LINE_W'(1);
            r_tok_col    <= COL_W'(1);
            r_ended      <= 1'b0;
        end else if (i_fire) begin
            r_mode       <= n_mode;
            r_held_char  <= n_held_char;
            r_held_valid <= n_held_valid;
            r_held_first <= n_held_first;
            r_tok_len    <= n_tok_len;
            r_line       <= n_line;
            r_col        <= n_col;
            r_tok_line   <= n_tok_line;
            r_tok_col    <= n_tok_col;
            r_ended      <= n_ended;
        end
    end

    assign o_push.cnt = i_fire ? w_cnt : 2'd0;
    assign o_push.r0  = w_res[0];
    assign o_push.r1  = w_res[1];

endmodule

FILE: hdl/sts_res_queue.sv
module sts_res_queue
    import sts_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_valid,
    output logic  o_room,
    output t_res  o_head
);

    logic [1:0] r_cnt, n_cnt;
    t_res       r_q [3];
    t_res       n_q [3];

    always_comb begin
        logic [1:0] v_cnt;
        n_q   = r_q;
        v_cnt = r_cnt;
        if (i_pop) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
            v_cnt  = r_cnt - 2'd1;
        end
        for (int i = 0; i < 3; i++) begin
            if (i_push.cnt != 2'd0 && 2'(i) == v_cnt) n_q[i] = i_push.r0;
            if (i_push.cnt == 2'd2 && 2'(i) == v_cnt + 2'd1) n_q[i] = i_push.r1;
        end
        n_cnt = v_cnt + i_push.cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_valid = (r_cnt != 2'd0);
    // room for the two results one byte can produce
    assign o_room  = (r_cnt <= 2'd1);
    assign o_head  = r_q[0];

endmodule

FILE: hdl/source_token_scanner.sv
// path: input register, scan logic, then the result queue that feeds the master side
// throughput: one input word per cycle while each byte yields at most one result word
//   and the master side takes every word; a byte that yields two words stalls the input
// reset: synchronous, active low; clears scan state, position to line 1 column 1,
//   max_token_len to 255 and empties the result queue
module source_token_scanner
    import sts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_char
    input  logic [0:0]  i_s_tuser,   // [0] at_end
    // token result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [7:0] tok_char, [8] is_first, [9] is_empty,
                                     // [25:10] start_line, [37:26] start_column, rest zero
    output logic [2:0]  o_m_tuser,   // [2:0] kind
    output logic        o_m_tlast,   // is_last
    // max_token_len register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    // config register
    logic [7:0] r_max_len;

    // input register stage
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_end;

    logic  w_fire;
    logic  w_room;
    logic  w_pop;
    t_push w_push;
    t_res  w_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= 8'd255;
        end else if (i_cfg_valid) begin
            r_max_len <= i_cfg_data;
        end
    end

    // the input register drains whenever the queue has room for two words;
    // ready depends on registered state only, no path from the master side
    assign w_fire     = r_in_valid && w_room;
    assign o_s_tready = !r_in_valid || w_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
            r_in_end  <= i_s_tuser[0];
        end
    end

    // per-byte scan rule and its state
    sts_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_char    (r_in_char),
        .i_end     (r_in_end),
        .i_max_len (r_max_len),
        .o_push    (w_push)
    );

    // result queue, three words deep
    assign w_pop = o_m_tvalid && i_m_tready;

    sts_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_valid (o_m_tvalid),
        .o_room  (w_room),
        .o_head  (w_head)
    );

    // pack the head word
    assign o_m_tdata = {2'b00, w_head.col, w_head.line, w_head.empty, w_head.first, w_head.ch};
    assign o_m_tuser = w_head.kind;
    assign o_m_tlast = w_head.last;

endmodule

FILE: hdl/sts_checker.sv
module sts_checker
    import sts_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata,
    input logic [2:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result word changed while stalled");

    // queue comes out of reset empty
    a_rst_empty: assert property (@(posedge i_clk) !$past(i_rst_n) |-> !o_m_tvalid)
        else $error("result valid right after reset");

    // end-of-file words are single, empty tokens
    a_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_EOF |-> o_m_tlast && o_m_tdata[8] && o_m_tdata[9])
        else $error("malformed end-of-file word");

    // only strings and end of file can be empty, and then carry no character
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[9] |->
            (o_m_tuser == KIND_EOF || o_m_tuser == KIND_QSTRING)
            && o_m_tdata[7:0] == 8'd0 && o_m_tdata[8] && o_m_tlast)
        else $error("bad empty token word");

endmodule

bind source_token_scanner sts_checker u_sts_checker (.*);

FILE: tb/sv/source_token_scanner_test.sv
`timescale 1ns / 100ps

module source_token_scanner_test;
    import sts_pkg::*;

    // no accepted word on any channel for this many cycles ends the run
    localparam int QUIET_LIMIT  = 2000;
    // cycles allowed for in-flight bytes that produce no word
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_OFF     = 300;

    // characters the scanner treats specially
    localparam logic [7:0] CH_SLASH   = "/";
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_DOT     = ".";
    localparam logic [7:0] CH_UNDER   = "_";
    localparam logic [7:0] CH_GT      = ">";
    localparam logic [7:0] CH_LT      = "<";
    localparam logic [7:0] CH_EQ      = "=";
    localparam logic [7:0] CH_BANG    = "!";
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = " ";
    localparam logic [15:0] LINE_MAX  = 16'hFFFF;
    localparam logic [11:0] COL_MAX   = 12'hFFF;

    typedef enum logic [2:0] {
        SC_IDLE, SC_SLASH, SC_COMMENT, SC_NUMBER, SC_QSTRING, SC_BAREWORD, SC_CMP
    } t_scan_state;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;   // [7:0] tok_char, [8] is_first, [9] is_empty,
                            // [25:10] start_line, [37:26] start_column
    logic [2:0]  m_tuser;   // [2:0] kind
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    // test control
    bit          idle_on = 1'b1;
    int          hold_off_req = 0;
    int          rx_wait = 0;
    int          errors = 0;
    int          shown = 0;
    int          quiet = 0;

    // scanner shadow state
    t_scan_state scan_st;
    logic [7:0]  cut_cfg;
    logic [7:0]  held_ch;
    logic        held_ok;
    logic        held_head;
    logic [7:0]  tok_len;
    logic [15:0] line_pos;
    logic [11:0] col_pos;
    logic [15:0] tok_line;
    logic [11:0] tok_col;
    logic        at_eof;

    t_res        tokens_due[$];
    logic [7:0]  snip[$];

    always #5 clk = ~clk;

    source_token_scanner DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    // ---------------------------------------------------------------
    // character classes, C locale
    // ---------------------------------------------------------------
    function automatic bit is_space(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_word(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDER;
    endfunction

    function automatic bit is_cmp(logic [7:0] c);
        return c == CH_GT || c == CH_LT || c == CH_EQ || c == CH_BANG;
    endfunction

    // ---------------------------------------------------------------
    // token predictor
    // ---------------------------------------------------------------
    function automatic void scanner_clear();
        scan_st   = SC_IDLE;
        cut_cfg   = 8'd255;
        held_ch   = '0;
        held_ok   = 1'b0;
        held_head = 1'b0;
        tok_len   = '0;
        line_pos  = 16'd1;
        col_pos   = 12'd1;
        tok_line  = 16'd1;
        tok_col   = 12'd1;
        at_eof    = 1'b0;
    endfunction

    // a zero register still allows one character
    function automatic int cut_len();
        return cut_cfg == 8'd0 ? 1 : int'(cut_cfg);
    endfunction

    function automatic logic [2:0] scan_kind();
        case (scan_st)
            SC_NUMBER:   return KIND_NUMBER;
            SC_QSTRING:  return KIND_QSTRING;
            SC_BAREWORD: return KIND_BAREWORD;
            default:     return KIND_SYMBOL;
        endcase
    endfunction

    function automatic void push_word(logic [2:0] kind, logic [7:0] ch, logic first,
                                      logic last, logic empty, logic [15:0] line,
                                      logic [11:0] col);
        t_res w;
        w.kind  = kind;
        w.ch    = ch;
        w.first = first;
        w.last  = last;
        w.empty = empty;
        w.line  = line;
        w.col   = col;
        tokens_due.push_back(w);
    endfunction

    function automatic void emit_held(logic last);
        push_word(scan_kind(), held_ch, held_head, last, 1'b0, tok_line, tok_col);
    endfunction

    function automatic void hold_char(logic [7:0] c);
        held_ch   = c;
        held_ok   = 1'b1;
        held_head = 1'b1;
        tok_len   = 8'd1;
    endfunction

    // byte seen between tokens
    function automatic void start_token(logic [7:0] c);
        scan_st = SC_IDLE;
        if (is_space(c)) return;
        tok_line = line_pos;
        tok_col  = col_pos;
        if (c == CH_SLASH) begin
            scan_st = SC_SLASH;
        end else if (is_digit(c)) begin
            scan_st = SC_NUMBER;
            hold_char(c);
        end else if (c == CH_QUOTE) begin
            scan_st = SC_QSTRING;
            held_ok = 1'b0;
            tok_len = '0;
        end else if (is_alpha(c) || c == CH_UNDER) begin
            scan_st = SC_BAREWORD;
            hold_char(c);
        end else if (is_cmp(c)) begin
            scan_st = SC_CMP;
            hold_char(c);
        end else begin
            push_word(KIND_SYMBOL, c, 1'b1, 1'b1, 1'b0, tok_line, tok_col);
        end
    endfunction

    // grow the held token or close it and rescan the byte
    function automatic void grow_token(logic [7:0] c, bit member);
        if (member && int'(tok_len) < cut_len()) begin
            emit_held(1'b0);
            held_ch   = c;
            held_head = 1'b0;
            tok_len   = tok_len + 8'd1;
        end else begin
            emit_held(1'b1);
            held_ok = 1'b0;
            start_token(c);
        end
    endfunction

    function automatic void scan_byte(logic [7:0] c, logic end_mark);
        if (at_eof) begin
            push_word(KIND_EOF, 8'd0, 1'b1, 1'b1, 1'b1, line_pos, col_pos);
            return;
        end
        if (end_mark) begin
            if (scan_st == SC_SLASH)
                push_word(KIND_SYMBOL, CH_SLASH, 1'b1, 1'b1, 1'b0, tok_line, tok_col);
            else if (scan_st == SC_QSTRING && !held_ok)
                push_word(KIND_QSTRING, 8'd0, 1'b1, 1'b1, 1'b1, tok_line, tok_col);
            else if ((scan_st == SC_NUMBER || scan_st == SC_QSTRING ||
                      scan_st == SC_BAREWORD || scan_st == SC_CMP) && held_ok)
                emit_held(1'b1);
            scan_st = SC_IDLE;
            held_ok = 1'b0;
            at_eof  = 1'b1;
            push_word(KIND_EOF, 8'd0, 1'b1, 1'b1, 1'b1, line_pos, col_pos);
            return;
        end
        case (scan_st)
            SC_COMMENT: begin
                if (c == CH_NL) scan_st = SC_IDLE;
            end
            SC_SLASH: begin
                if (c == CH_SLASH) begin
                    scan_st = SC_COMMENT;
                end else begin
                    push_word(KIND_SYMBOL, CH_SLASH, 1'b1, 1'b1, 1'b0, tok_line, tok_col);
                    start_token(c);
                end
            end
            SC_NUMBER:   grow_token(c, is_digit(c) || c == CH_DOT);
            SC_BAREWORD: grow_token(c, is_word(c));
            SC_CMP:      grow_token(c, is_cmp(c));
            SC_QSTRING: begin
                if (c == CH_QUOTE) begin
                    // closing quote, even right after a cut
                    if (held_ok)
                        emit_held(1'b1);
                    else
                        push_word(KIND_QSTRING, 8'd0, 1'b1, 1'b1, 1'b1, tok_line, tok_col);
                    held_ok = 1'b0;
                    scan_st = SC_IDLE;
                end else if (!held_ok) begin
                    hold_char(c);
                end else begin
                    grow_token(c, 1'b1);
                end
            end
            default: start_token(c);
        endcase
        // position, saturating
        if (c == CH_NL) begin
            if (line_pos != LINE_MAX) line_pos = line_pos + 16'd1;
            col_pos = 12'd1;
        end else if (col_pos != COL_MAX) begin
            col_pos = col_pos + 12'd1;
        end
    endfunction

    function automatic string word_text(t_res w);
        return $sformatf("kind=%0d ch=%02h first=%0b last=%0b empty=%0b line=%0d col=%0d",
                         w.kind, w.ch, w.first, w.last, w.empty, w.line, w.col);
    endfunction

    // ---------------------------------------------------------------
    // monitor: predicts on accepted bytes, checks every result word,
    // tracks register writes and the quiet-cycle watchdog
    // ---------------------------------------------------------------
    always @(posedge clk) begin : monitor
        t_res got;
        t_res want;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) cut_cfg = cfg_data;
            if (s_tvalid && s_tready) scan_byte(s_tdata, s_tuser[0]);
            if (m_tvalid && m_tready) begin
                got.kind  = m_tuser;
                got.ch    = m_tdata[7:0];
                got.first = m_tdata[8];
                got.empty = m_tdata[9];
                got.line  = m_tdata[25:10];
                got.col   = m_tdata[37:26];
                got.last  = m_tlast;
                if (tokens_due.size() == 0) begin
                    errors++;
                    if (shown < 20) begin
                        shown++;
                        $display("%0t: unexpected word, expected none, actual %s",
                                 $time, word_text(got));
                    end
                end else begin
                    want = tokens_due.pop_front();
                    if (got.kind !== want.kind || got.ch !== want.ch ||
                        got.first !== want.first || got.last !== want.last ||
                        got.empty !== want.empty || got.line !== want.line ||
                        got.col !== want.col) begin
                        errors++;
                        if (shown < 20) begin
                            shown++;
                            $display("%0t: mismatch, expected %s, actual %s",
                                     $time, word_text(want), word_text(got));
                        end
                    end
                end
            end
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("%0t: no word accepted for %0d cycles, %0d words still due",
                         $time, quiet, tokens_due.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // result receiver: random stalls per word, long hold-off on request
    // ---------------------------------------------------------------
    always @(posedge clk) begin : receiver
        int gap;
        if (!rst_n) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end else if (hold_off_req != 0) begin
            m_tready <= 1'b0;
            rx_wait  <= hold_off_req;
            hold_off_req = 0;
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
        end else if (!m_tready) begin
            m_tready <= 1'b1;
        end else if (m_tvalid) begin
            gap = idle_on ? $urandom_range(0, 7) : 0;
            if (gap != 0) begin
                m_tready <= 1'b0;
                rx_wait  <= gap - 1;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    // valid stays high between back-to-back bytes; it only drops for a gap
    task automatic send_word(input logic [7:0] c, input logic end_mark);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= c;
        s_tuser[0] <= end_mark;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
    endtask

    task automatic send_snippet();
        foreach (snip[i]) send_word(snip[i], 1'b0);
    endtask

    // register write once every due word is out and the pipe is empty
    task automatic write_cut_len(input logic [7:0] v);
        while (tokens_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] rand_letter();
        return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                    : 8'("A" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_word_char();
        case ($urandom_range(0, 3))
            0:       return 8'("0" + $urandom_range(0, 9));
            1:       return CH_UNDER;
            default: return rand_letter();
        endcase
    endfunction

    function automatic logic [7:0] rand_cmp();
        case ($urandom_range(0, 3))
            0:       return CH_GT;
            1:       return CH_LT;
            2:       return CH_EQ;
            default: return CH_BANG;
        endcase
    endfunction

    // any byte that forms a single-symbol token on its own
    function automatic logic [7:0] rand_symbol();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (is_space(c) || is_word(c) || is_cmp(c) || c == CH_QUOTE || c == CH_SLASH)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] rand_printable();
        logic [7:0] c;
        c = 8'($urandom_range(32, 126));
        return c == CH_QUOTE ? "q" : c;
    endfunction

    // one piece of source text, mostly well formed
    function automatic void build_snippet();
        int n;
        snip.delete();
        case ($urandom_range(0, 19))
            0, 1, 2: begin
                snip.push_back(8'("0" + $urandom_range(0, 9)));
                n = $urandom_range(0, 5);
                repeat (n) snip.push_back($urandom_range(0, 3) == 0 ? CH_DOT
                                          : 8'("0" + $urandom_range(0, 9)));
            end
            3, 4: begin
                snip.push_back(CH_QUOTE);
                n = $urandom_range(0, 6);
                repeat (n) snip.push_back($urandom_range(0, 7) == 0 ? CH_NL : rand_printable());
                // now and then leave the string open
                if ($urandom_range(0, 6) != 0) snip.push_back(CH_QUOTE);
            end
            5, 6, 7: begin
                snip.push_back($urandom_range(0, 4) == 0 ? CH_UNDER : rand_letter());
                n = $urandom_range(0, 6);
                repeat (n) snip.push_back(rand_word_char());
            end
            8, 9: begin
                n = $urandom_range(1, 4);
                repeat (n) snip.push_back(rand_cmp());
            end
            10, 11: snip.push_back(rand_symbol());
            12, 13, 14: begin
                n = $urandom_range(1, 3);
                repeat (n) snip.push_back($urandom_range(0, 5) == 5 ? CH_SPACE
                                          : 8'(CH_TAB + $urandom_range(0, 4)));
            end
            15: begin
                snip.push_back(CH_SLASH);
                snip.push_back(CH_SLASH);
                n = $urandom_range(0, 8);
                repeat (n) snip.push_back(rand_printable());
                if ($urandom_range(0, 4) != 0) snip.push_back(CH_NL);
            end
            16: snip.push_back(CH_SLASH);
            17, 18: begin
                // raw noise over the whole byte range
                n = $urandom_range(1, 2);
                repeat (n) snip.push_back(8'($urandom_range(0, 255)));
            end
            default: snip.push_back(CH_SPACE);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    // every token kind but end of file, empty string, comparison run ended
    // by a rescanned slash, lone slash, comment, NUL and top byte as symbols
    task automatic test_directed_tokens();
        send_text("a_9 0.1\"q\"\"\">=/x//c\n");
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        stop_sending();
    endtask

    // short limits: cut number, bareword, run, and a cut string closed by
    // a quote or ended by another byte; zero acts as one
    task automatic test_token_cut();
        write_cut_len(8'd2);
        send_text("abc 12345 \"xy\"\"xyz\">>=\n");
        stop_sending();
        write_cut_len(8'd0);
        send_text("ab\"\"q!=\n");
        stop_sending();
    endtask

    // receiver holds off for a long stretch while bytes keep coming
    task automatic test_back_pressure();
        write_cut_len(8'd255);
        idle_on = 1'b0;
        hold_off_req = HOLD_OFF;
        repeat (40) send_word(rand_symbol(), 1'b0);
        stop_sending();
        idle_on = 1'b1;
    endtask

    task automatic test_random_text();
        logic [7:0] lens[7];
        int sent;
        lens = '{8'd1, 8'd0, 8'd3, 8'd255, 8'd0, 8'd2, 8'd255};
        lens[4] = 8'($urandom_range(4, 12));
        foreach (lens[p]) begin
            write_cut_len(lens[p]);
            idle_on = $urandom_range(0, 3) != 0;
            sent = 0;
            while (sent < 16) begin
                build_snippet();
                send_snippet();
                sent += snip.size();
            end
            stop_sending();
        end
        idle_on = 1'b1;
    endtask

    // end mark in a random place, then more items after the end
    task automatic test_end_of_input();
        case ($urandom_range(0, 5))
            0: send_text("ab");
            1: send_text("//x");
            2: send_text("/");
            3: send_text("\"");
            4: send_text("\"k");
            default: send_text("7 ");
        endcase
        send_word(8'($urandom_range(0, 255)), 1'b1);
        repeat (3) send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        stop_sending();
    endtask

    initial begin : run
        int waited;
        scanner_clear();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_tokens();
        test_token_cut();
        test_back_pressure();
        test_random_text();
        test_end_of_input();
        waited = 0;
        while (tokens_due.size() != 0 && waited < QUIET_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (tokens_due.size() != 0) begin
            errors++;
            $display("%0t: %0d words never arrived, expected next %s",
                     $time, tokens_due.size(), word_text(tokens_due[0]));
        end
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/sts_pkg.sv
hdl/sts_scan.sv
hdl/sts_res_queue.sv
hdl/source_token_scanner.sv
hdl/sts_checker.sv
tb/sv/source_token_scanner_test.sv
